// ===== sv/mmcs_pkg.sv =====
`default_nettype none

package mmcs_pkg;

    // Field widths of the streams
    localparam int DATA_W     = 32;
    localparam int IDX_W      = 12;
    localparam int S_TDATA_W  = 48;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 48;
    localparam int M_TUSER_W  = 1;
    localparam int CFG_ADDR_W = 1;

    // Bit positions inside s_axis_tuser
    localparam int TU_OP    = 0;
    localparam int TU_FIRST = 1;

    // Item kinds
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_OUT_MAX = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_OUT_MIN = 1'b1;

    localparam logic signed [DATA_W-1:0] OUT_MAX_RST = 32'sd65536;
    localparam logic signed [DATA_W-1:0] OUT_MIN_RST = 32'sd0;
    localparam logic signed [DATA_W-1:0] S32_MAX     = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] S32_MIN     = 32'sh8000_0000;

    // Arithmetic widths
    localparam int FRAC_W    = 16;
    localparam int RANGE_W   = DATA_W + 1;          // max - min, out_max - out_min
    localparam int NUM_W     = RANGE_W + FRAC_W;    // magnitude of the scaled numerator
    localparam int DIV_STEPS = NUM_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);
    localparam int PROD_W    = 2 * DATA_W;
    localparam int SUM_W     = PROD_W - FRAC_W + 1;

endpackage

`default_nettype wire

// ===== sv/image_min_max_contrast_stretch.sv =====
// Channel   Dir  Beat contents (lowest bit first)
// s_axis    in   tdata: value[31:0], index[43:32]; tuser: op[0], first[1]
// m_axis    out  tdata: scaled[31:0], position[43:32]; tuser: bad_index[0]
// cfg       in   cfg_addr 0 = out_max, 1 = out_min; cfg_data 32 bits
//
// A load beat is taken in the idle state and the input stays ready behind it.
// A fetch steps through store read, multiply, add and saturate, and output;
// a bad index or a flat frame skips from the store read to the output. The first
// scaling fetch after a load or a register write also runs the bit-serial divider.
// The output register holds a result while m_axis stalls; the sequencer waits
// only when a second result is ready before the first was taken.
// Reset is asynchronous and needs no clearing pass; the frame store is not reset.
`default_nettype none

module image_min_max_contrast_stretch #(
    parameter int MAX_PIXELS = 4096,
    parameter int PIXEL_BITS = 32
) (
    input  wire                                      clk,
    input  wire                                      rst_n,
    input  wire                                      s_axis_tvalid,
    output logic                                     s_axis_tready,
    // value[31:0], index[43:32], zero fill
    input  wire  [mmcs_pkg::S_TDATA_W-1:0]           s_axis_tdata,
    // op[0], first[1]
    input  wire  [mmcs_pkg::S_TUSER_W-1:0]           s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  wire                                      m_axis_tready,
    // scaled[31:0], position[43:32], zero fill
    output logic [mmcs_pkg::M_TDATA_W-1:0]           m_axis_tdata,
    // bad_index[0]
    output logic [mmcs_pkg::M_TUSER_W-1:0]           m_axis_tuser,
    input  wire                                      cfg_wr_en,
    input  wire  [mmcs_pkg::CFG_ADDR_W-1:0]          cfg_addr,
    input  wire  [mmcs_pkg::DATA_W-1:0]              cfg_data
);

    import mmcs_pkg::*;

    localparam int PIX_W  = (PIXEL_BITS < DATA_W) ? PIXEL_BITS : DATA_W;
    localparam int ADDR_W = $clog2(MAX_PIXELS);
    localparam int CNT_W  = $clog2(MAX_PIXELS + 1);
    localparam int CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_PIXELS);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_SCL  = 3'd3;
    localparam logic [2:0] ST_MUL  = 3'd4;
    localparam logic [2:0] ST_ADD  = 3'd5;
    localparam logic [2:0] ST_FIN  = 3'd6;

    logic [PIX_W-1:0] frame_mem [MAX_PIXELS];

    logic [2:0]                  state_reg, state_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic signed [DATA_W-1:0]    min_reg, min_next;
    logic signed [DATA_W-1:0]    max_reg, max_next;
    logic signed [DATA_W-1:0]    out_max_reg, out_max_next;
    logic signed [DATA_W-1:0]    out_min_reg, out_min_next;
    logic signed [DATA_W-1:0]    scale_reg, scale_next;
    logic                        scale_ok_reg, scale_ok_next;
    logic [PIX_W-1:0]            rd_data_reg;
    logic [IDX_W-1:0]            pos_reg, pos_next;
    logic                        bad_reg, bad_next;
    logic                        flat_reg, flat_next;
    logic signed [RANGE_W-1:0]   diff_reg, diff_next;
    logic [NUM_W-1:0]            dq_reg, dq_next;
    logic [RANGE_W-1:0]          rem_reg, rem_next;
    logic [RANGE_W-1:0]          dvsr_reg, dvsr_next;
    logic                        neg_reg, neg_next;
    logic [DIV_CNT_W-1:0]        step_reg, step_next;
    logic signed [PROD_W-1:0]    prod_reg, prod_next;
    logic signed [DATA_W-1:0]    res_reg, res_next;
    logic                        out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0]    out_scaled_reg, out_scaled_next;
    logic [IDX_W-1:0]            out_pos_reg, out_pos_next;
    logic                        out_bad_reg, out_bad_next;

    logic                        in_fire;
    logic                        in_op;
    logic                        in_first;
    logic signed [DATA_W-1:0]    in_pix;
    logic [IDX_W-1:0]            in_idx;
    logic [CMP_W-1:0]            idx_ext;
    logic                        wr_en;
    logic [ADDR_W-1:0]           wr_addr;
    logic                        rd_en;
    logic [CNT_W-1:0]            base_cnt;
    logic signed [DATA_W-1:0]    base_min;
    logic signed [DATA_W-1:0]    base_max;
    logic signed [DATA_W-1:0]    rd_pix;
    logic signed [RANGE_W-1:0]   span;
    logic [RANGE_W-1:0]          span_mag;
    logic [RANGE_W:0]            shifted;
    logic [RANGE_W+1:0]          trial;
    logic signed [PROD_W:0]      prod_full;
    logic signed [SUM_W-1:0]     sum;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign in_op    = s_axis_tuser[TU_OP];
    assign in_first = s_axis_tuser[TU_FIRST];
    assign in_pix   = DATA_W'(signed'(s_axis_tdata[PIX_W-1:0]));
    assign in_idx   = s_axis_tdata[DATA_W +: IDX_W];
    assign idx_ext  = CMP_W'(in_idx);
    assign rd_pix   = DATA_W'(signed'(rd_data_reg));

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(M_TDATA_W - IDX_W - DATA_W)'(0), out_pos_reg, out_scaled_reg};
    assign m_axis_tuser  = out_bad_reg;

    // A new frame restarts from an empty count and cleared extremes.
    assign base_cnt = in_first ? '0 : count_reg;
    assign base_min = in_first ? S32_MAX : min_reg;
    assign base_max = in_first ? S32_MIN : max_reg;

    assign wr_en   = in_fire && (in_op == OP_LOAD) && (base_cnt < CNT_FULL);
    assign wr_addr = base_cnt[ADDR_W-1:0];
    assign rd_en   = in_fire && (in_op == OP_FETCH);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            frame_mem[wr_addr] <= in_pix[PIX_W-1:0];
        end
        if (rd_en)
        begin
            rd_data_reg <= frame_mem[idx_ext[ADDR_W-1:0]];
        end
    end

    // Combinational datapath pieces
    assign span     = RANGE_W'(out_max_reg) - RANGE_W'(out_min_reg);
    assign span_mag = span[RANGE_W-1] ? RANGE_W'(-span) : RANGE_W'(span);
    assign shifted  = {rem_reg, dq_reg[NUM_W-1]};
    assign trial    = {1'b0, shifted} - {2'b0, dvsr_reg};
    assign prod_full = (PROD_W + 1)'(scale_reg) * (PROD_W + 1)'(diff_reg);
    // Taking the upper product bits as signed is the floor shift by the fraction width.
    assign sum      = SUM_W'(signed'(prod_reg[PROD_W-1:FRAC_W])) + SUM_W'(out_min_reg);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        min_next        = min_reg;
        max_next        = max_reg;
        out_max_next    = out_max_reg;
        out_min_next    = out_min_reg;
        scale_next      = scale_reg;
        scale_ok_next   = scale_ok_reg;
        pos_next        = pos_reg;
        bad_next        = bad_reg;
        flat_next       = flat_reg;
        diff_next       = diff_reg;
        dq_next         = dq_reg;
        rem_next        = rem_reg;
        dvsr_next       = dvsr_reg;
        neg_next        = neg_reg;
        step_next       = step_reg;
        prod_next       = prod_reg;
        res_next        = res_reg;
        out_valid_next  = out_valid_reg;
        out_scaled_next = out_scaled_reg;
        out_pos_next    = out_pos_reg;
        out_bad_next    = out_bad_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_OUT_MAX: out_max_next = cfg_data;
                REG_OUT_MIN: out_min_next = cfg_data;
                default: ;
            endcase
            scale_ok_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_op == OP_LOAD)
                    begin
                        scale_ok_next = 1'b0;
                        count_next    = base_cnt;
                        min_next      = base_min;
                        max_next      = base_max;
                        if (base_cnt < CNT_FULL)
                        begin
                            count_next = base_cnt + CNT_W'(1);
                            if (in_pix < base_min)
                            begin
                                min_next = in_pix;
                            end
                            if (in_pix > base_max)
                            begin
                                max_next = in_pix;
                            end
                        end
                    end
                    else
                    begin
                        pos_next   = in_idx;
                        bad_next   = (idx_ext >= CMP_W'(count_reg));
                        flat_next  = (max_reg <= min_reg);
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                diff_next = RANGE_W'(rd_pix) - RANGE_W'(min_reg);
                if (bad_reg)
                begin
                    res_next   = '0;
                    state_next = ST_FIN;
                end
                else if (flat_reg)
                begin
                    res_next   = out_min_reg;
                    state_next = ST_FIN;
                end
                else if (scale_ok_reg)
                begin
                    state_next = ST_MUL;
                end
                else
                begin
                    dq_next    = {span_mag, FRAC_W'(0)};
                    neg_next   = span[RANGE_W-1];
                    dvsr_next  = RANGE_W'(max_reg) - RANGE_W'(min_reg);
                    rem_next   = '0;
                    step_next  = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // Restoring division, one quotient bit per cycle.
                if (!trial[RANGE_W+1])
                begin
                    rem_next = trial[RANGE_W-1:0];
                    dq_next  = {dq_reg[NUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = shifted[RANGE_W-1:0];
                    dq_next  = {dq_reg[NUM_W-2:0], 1'b0};
                end
                step_next = step_reg + DIV_CNT_W'(1);
                if (step_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_SCL;
                end
            end
            ST_SCL:
            begin
                if (neg_reg)
                begin
                    if (dq_reg > NUM_W'(64'h8000_0000))
                    begin
                        scale_next = S32_MIN;
                    end
                    else
                    begin
                        scale_next = DATA_W'(-dq_reg);
                    end
                end
                else if (dq_reg > NUM_W'(64'h7FFF_FFFF))
                begin
                    scale_next = S32_MAX;
                end
                else
                begin
                    scale_next = DATA_W'(dq_reg);
                end
                scale_ok_next = 1'b1;
                state_next    = ST_MUL;
            end
            ST_MUL:
            begin
                prod_next  = prod_full[PROD_W-1:0];
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                if (sum > SUM_W'(S32_MAX))
                begin
                    res_next = S32_MAX;
                end
                else if (sum < SUM_W'(S32_MIN))
                begin
                    res_next = S32_MIN;
                end
                else
                begin
                    res_next = DATA_W'(sum);
                end
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_scaled_next = res_reg;
                    out_pos_next    = pos_reg;
                    out_bad_next    = bad_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            min_reg       <= S32_MAX;
            max_reg       <= S32_MIN;
            out_max_reg   <= OUT_MAX_RST;
            out_min_reg   <= OUT_MIN_RST;
            scale_reg     <= '0;
            scale_ok_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            out_max_reg   <= out_max_next;
            out_min_reg   <= out_min_next;
            scale_reg     <= scale_next;
            scale_ok_reg  <= scale_ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        bad_reg        <= bad_next;
        flat_reg       <= flat_next;
        diff_reg       <= diff_next;
        dq_reg         <= dq_next;
        rem_reg        <= rem_next;
        dvsr_reg       <= dvsr_next;
        neg_reg        <= neg_next;
        step_reg       <= step_next;
        prod_reg       <= prod_next;
        res_reg        <= res_next;
        out_scaled_reg <= out_scaled_next;
        out_pos_reg    <= out_pos_next;
        out_bad_reg    <= out_bad_next;
    end

endmodule

`default_nettype wire

// ===== sv/mmcs_checker.sv =====
`default_nettype none

module mmcs_checker (
    input wire                                clk,
    input wire                                rst_n,
    input wire                                s_axis_tvalid,
    input wire                                s_axis_tready,
    input wire [mmcs_pkg::S_TUSER_W-1:0]      s_axis_tuser,
    input wire                                m_axis_tvalid,
    input wire                                m_axis_tready,
    input wire [mmcs_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    input wire [mmcs_pkg::M_TUSER_W-1:0]      m_axis_tuser
);

    import mmcs_pkg::*;

    // A beat on the output holds until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output beat changed while stalled");

    // A fetch occupies the sequencer, so the input drops ready behind it.
    a_fetch_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser[TU_OP] == OP_FETCH)
        |=> !s_axis_tready)
        else $error("input ready right after a fetch");

    // A load completes in its own cycle.
    a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser[TU_OP] == OP_LOAD)
        |=> s_axis_tready)
        else $error("input not ready after a load");

    // A bad index always reports a zero pixel.
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> (m_axis_tdata[DATA_W-1:0] == '0))
        else $error("bad index result is not zero");

endmodule

bind image_min_max_contrast_stretch mmcs_checker u_mmcs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ===== test/tb_image_min_max_contrast_stretch.sv =====
`timescale 1ns / 100ps

typedef struct {
    logic signed [31:0] scaled;
    logic [11:0]        position;
    logic               bad_index;
} stretch_result_t;

typedef enum int {PIX_ANY, PIX_NARROW, PIX_FLAT, PIX_EXTREME, PIX_SMALL} pixel_style_t;

class stretch_scoreboard #(int DEPTH = 4096);
    logic signed [31:0] pixels [DEPTH];
    int unsigned        count;
    logic signed [31:0] frame_lo;
    logic signed [31:0] frame_hi;
    logic signed [31:0] gain;
    bit                 gain_valid;
    logic signed [31:0] target_hi;
    logic signed [31:0] target_lo;
    stretch_result_t    stretched_q [$];
    int                 mismatches;

    function new();
        count      = 0;
        frame_lo   = mmcs_pkg::S32_MAX;
        frame_hi   = mmcs_pkg::S32_MIN;
        gain       = '0;
        gain_valid = 1'b0;
        target_hi  = mmcs_pkg::OUT_MAX_RST;
        target_lo  = mmcs_pkg::OUT_MIN_RST;
        mismatches = 0;
    endfunction

    function logic signed [31:0] clamp32(longint v);
        if (v > longint'(mmcs_pkg::S32_MAX))
            return mmcs_pkg::S32_MAX;
        if (v < longint'(mmcs_pkg::S32_MIN))
            return mmcs_pkg::S32_MIN;
        return v[31:0];
    endfunction

    function void write_reg(logic [mmcs_pkg::CFG_ADDR_W-1:0] addr, logic signed [31:0] data);
        if (addr == mmcs_pkg::REG_OUT_MAX)
            target_hi = data;
        else
            target_lo = data;
        gain_valid = 1'b0;
    endfunction

    // Called once per accepted input beat, in acceptance order.
    function void apply_item(logic op, logic first, logic signed [31:0] value,
                             logic [11:0] index);
        stretch_result_t want;
        longint          span;
        longint          num;
        longint          prod;
        longint          acc;
        if (op == mmcs_pkg::OP_LOAD)
        begin
            gain_valid = 1'b0;
            if (first)
            begin
                count    = 0;
                frame_lo = mmcs_pkg::S32_MAX;
                frame_hi = mmcs_pkg::S32_MIN;
            end
            // A full store drops the pixel.
            if (count < DEPTH)
            begin
                pixels[count] = value;
                count++;
                if (value < frame_lo)
                    frame_lo = value;
                if (value > frame_hi)
                    frame_hi = value;
            end
            return;
        end
        want.position = index;
        if (index >= count)
        begin
            want.scaled    = '0;
            want.bad_index = 1'b1;
        end
        else
        begin
            want.bad_index = 1'b0;
            span = longint'(frame_hi) - longint'(frame_lo);
            if (span <= 0)
            begin
                acc = longint'(target_lo);
            end
            else
            begin
                if (!gain_valid)
                begin
                    num        = (longint'(target_hi) - longint'(target_lo)) * 65536;
                    gain       = clamp32(num / span);
                    gain_valid = 1'b1;
                end
                prod = longint'(gain) * (longint'(pixels[index]) - longint'(frame_lo));
                acc  = longint'(target_lo) + (prod >>> 16);
            end
            want.scaled = clamp32(acc);
        end
        stretched_q.push_back(want);
    endfunction

    function void check_pixel(logic [mmcs_pkg::M_TDATA_W-1:0] beat_data,
                              logic [mmcs_pkg::M_TUSER_W-1:0] beat_user);
        stretch_result_t got;
        stretch_result_t want;
        got.scaled    = beat_data[mmcs_pkg::DATA_W-1:0];
        got.position  = beat_data[mmcs_pkg::DATA_W +: mmcs_pkg::IDX_W];
        got.bad_index = beat_user[0];
        if (stretched_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: unexpected beat scaled %h position %0d bad_index %0b",
                         $time, got.scaled, got.position, got.bad_index);
            return;
        end
        want = stretched_q.pop_front();
        if (got.scaled !== want.scaled || got.position !== want.position ||
            got.bad_index !== want.bad_index)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: scaled exp %h got %h, pos exp %0d got %0d, bad exp %0b got %0b",
                         $time, want.scaled, got.scaled, want.position, got.position,
                         want.bad_index, got.bad_index);
        end
    endfunction

    function int pending();
        return stretched_q.size();
    endfunction

    function int failures();
        return mismatches + stretched_q.size();
    endfunction
endclass

module tb_image_min_max_contrast_stretch;
    import mmcs_pkg::*;

    localparam int FRAME_DEPTH = 4096;
    localparam int RAND_ITEMS  = 1120;
    localparam int IDLE_GAP    = 16;
    localparam int END_WAIT    = 64;
    localparam int TIMEOUT_NS  = 2_000_000;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     s_axis_tvalid;
    logic                     s_axis_tready;
    logic [S_TDATA_W-1:0]     s_axis_tdata;
    logic [S_TUSER_W-1:0]     s_axis_tuser;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]     m_axis_tdata;
    logic [M_TUSER_W-1:0]     m_axis_tuser;
    logic                     cfg_wr_en;
    logic [CFG_ADDR_W-1:0]    cfg_addr;
    logic [DATA_W-1:0]        cfg_data;

    stretch_scoreboard #(FRAME_DEPTH) sb;
    int                       burst_left = 0;
    int                       items_sent = 0;
    int                       stall_left = 0;
    int                       stall_mode = 0;

    image_min_max_contrast_stretch #(
        .MAX_PIXELS(FRAME_DEPTH),
        .PIXEL_BITS(32)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Output side: check every accepted beat and change the stall pattern when its
    // random run length runs out.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_pixel(m_axis_tdata, m_axis_tuser);
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(16, 96);
        end
        else
        begin
            stall_left--;
        end
        case (stall_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= ~m_axis_tready;
        endcase
    end

    function automatic logic [31:0] pixel_value(pixel_style_t style, logic [31:0] base);
        case (style)
            PIX_ANY:    return $urandom;
            PIX_NARROW: return base + $urandom_range(0, 255);
            PIX_FLAT:   return base;
            PIX_EXTREME:
            begin
                case ($urandom_range(0, 4))
                    0:       return S32_MIN;
                    1:       return S32_MAX;
                    2:       return '0;
                    3:       return '1;
                    default: return $urandom;
                endcase
            end
            default:    return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
        endcase
    endfunction

    task automatic send_beat(input logic op, input logic first, input logic [31:0] value,
                             input logic [11:0] index);
        logic [S_TUSER_W-1:0] kind;
        if (burst_left == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(32, 128)
                                                     : $urandom_range(1, 12);
        end
        kind           = '0;
        kind[TU_OP]    = op;
        kind[TU_FIRST] = first;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_TDATA_W - DATA_W - IDX_W){1'b0}}, index, value};
        s_axis_tuser  <= kind;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        burst_left--;
        sb.apply_item(op, first, value, index);
        items_sent++;
    endtask

    task automatic load_pixel(input logic first, input logic [31:0] value);
        send_beat(OP_LOAD, first, value, 12'($urandom_range(0, 4095)));
    endtask

    task automatic fetch_pixel(input logic [11:0] index);
        send_beat(OP_FETCH, 1'($urandom_range(0, 1)), $urandom, index);
    endtask

    // Called right after an accepted beat, so the stale beat is withdrawn in time.
    task automatic stop_input();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
    endtask

    task automatic drain(input int settle);
        while (sb.pending() != 0) @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic set_range(input logic [31:0] hi, input logic [31:0] lo);
        logic hi_first;
        hi_first = 1'($urandom_range(0, 1));
        cfg_wr_en <= 1'b1;
        cfg_addr  <= hi_first ? REG_OUT_MAX : REG_OUT_MIN;
        cfg_data  <= hi_first ? hi : lo;
        @(posedge clk);
        sb.write_reg(hi_first ? REG_OUT_MAX : REG_OUT_MIN, hi_first ? hi : lo);
        cfg_addr  <= hi_first ? REG_OUT_MIN : REG_OUT_MAX;
        cfg_data  <= hi_first ? lo : hi;
        @(posedge clk);
        sb.write_reg(hi_first ? REG_OUT_MIN : REG_OUT_MAX, hi_first ? lo : hi);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic fetch_mix(input int n, input pixel_style_t style, input logic [31:0] base);
        int pick;
        for (int j = 0; j < n; j++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                load_pixel(1'b0, pixel_value(style, base));
            else if (pick < 16)
                fetch_pixel(12'($urandom_range(0, 4095)));
            else if (pick < 22)
                fetch_pixel(12'(sb.count));
            else
                fetch_pixel((sb.count == 0) ? 12'd0 : 12'($urandom_range(0, sb.count - 1)));
        end
    endtask

    // Mostly a fresh frame, now and then appended to the previous one.
    task automatic run_frame();
        pixel_style_t style;
        logic [31:0]  base;
        int           len;
        style = pixel_style_t'($urandom_range(0, 4));
        base  = $urandom;
        case ($urandom_range(0, 9))
            0:       len = $urandom_range(65, 300);
            1, 2:    len = $urandom_range(17, 64);
            default: len = $urandom_range(1, 16);
        endcase
        for (int i = 0; i < len; i++)
            load_pixel((i == 0) ? ($urandom_range(0, 19) != 0) : 1'b0, pixel_value(style, base));
        fetch_mix($urandom_range(1, 24), style, base);
    endtask

    task automatic run_phase(input int k, input int target);
        int phase_end;
        stop_input();
        drain(IDLE_GAP);
        case (k)
            0:       set_range(32'h0001_0000, 32'h0000_0000);
            1:       set_range(S32_MAX, S32_MIN);
            2:       set_range(S32_MIN, S32_MAX);
            3:       set_range(32'h00FF_0000, 32'h0000_0000);
            4:       set_range(32'h4000_0000, 32'h4000_0000);
            5:       set_range(32'hFFFF_0000, 32'h0001_0000);
            default: set_range($urandom, $urandom);
        endcase
        phase_end = items_sent + $urandom_range(100, 160);
        // Fetching the old frame under the new range forces a fresh divide.
        if (sb.count != 0 && $urandom_range(0, 1))
            fetch_mix($urandom_range(2, 10), PIX_ANY, 32'h0);
        while (items_sent < phase_end && items_sent < target)
            run_frame();
    endtask

    initial
    begin
        #(TIMEOUT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        int target;
        int k;
        sb = new();
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        cfg_wr_en     <= 1'b0;
        cfg_addr      <= '0;
        cfg_data      <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty frame right after reset.
        fetch_pixel(12'd0);
        fetch_pixel(12'hFFF);
        // Full-scale extremes in one frame.
        load_pixel(1'b1, S32_MIN);
        load_pixel(1'b0, S32_MAX);
        load_pixel(1'b0, 32'h0000_0000);
        load_pixel(1'b0, 32'h0001_0000);
        load_pixel(1'b0, 32'hFFFF_FFFF);
        for (int i = 0; i < 5; i++)
            fetch_pixel(12'(i));
        fetch_pixel(12'd5);
        // Flat frame.
        load_pixel(1'b1, 32'h1234_5678);
        load_pixel(1'b0, 32'h1234_5678);
        load_pixel(1'b0, 32'h1234_5678);
        fetch_pixel(12'd0);
        fetch_pixel(12'd2);
        fetch_pixel(12'd3);
        // Cached scale, then a load that invalidates it.
        load_pixel(1'b1, 32'h0001_0000);
        load_pixel(1'b0, 32'h0002_0000);
        fetch_pixel(12'd1);
        fetch_pixel(12'd0);
        load_pixel(1'b0, 32'h0003_0000);
        fetch_pixel(12'd2);

        target = items_sent + RAND_ITEMS;
        k = 0;
        while (items_sent < target)
        begin
            run_phase(k, target);
            k++;
        end

        stop_input();
        drain(END_WAIT);
        if (sb.failures() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

// ===== image_min_max_contrast_stretch.f =====
sv/mmcs_pkg.sv
sv/image_min_max_contrast_stretch.sv
sv/mmcs_checker.sv
test/tb_image_min_max_contrast_stretch.sv
